FILE: hdl/cttok_pkg.sv
// Package for the command text tokenizer: token kinds, scanner modes,
// character codes and character-class helpers. No dependencies.
package cttok_pkg;

    // Longest token text kept, in characters
    localparam int MAX_TOKEN_CHARS_DEF = 8;
    localparam int TEXT_BYTES          = 8;

    // Result token kinds
    typedef enum logic [3:0] {
        KIND_CMD_START = 4'd0,
        KIND_CMD_END   = 4'd1,
        KIND_DOT       = 4'd2,
        KIND_COLON     = 4'd3,
        KIND_NUMBER    = 4'd4,
        KIND_HEX       = 4'd5,
        KIND_IDENT     = 4'd6,
        KIND_ERROR     = 4'd7,
        KIND_EOT       = 4'd8
    } token_kind_t;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_ZERO   = 3'd1,
        MODE_PREFIX = 3'd2,
        MODE_DEC    = 3'd3,
        MODE_HEX    = 3'd4,
        MODE_IDENT  = 3'd5
    } mode_t;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UPX   = 8'h58;
    localparam logic [7:0] CH_LOWX  = 8'h78;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_name_start(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_UNDER);
    endfunction

    // Digit value of a decimal or hex character, zero for anything else
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if ((c >= 8'h61) && (c <= 8'h66)) begin
            v = 4'(c - 8'h57);
        end
        else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = 4'(c - 8'h37);
        end
        else if (is_digit(c)) begin
            v = c[3:0];
        end
        return v;
    endfunction

endpackage

FILE: hdl/cttok_char_if.sv
// Character channel: one text character per beat.
// No dependencies.
interface cttok_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

FILE: hdl/cttok_token_if.sv
// Token channel: one result token per beat.
// Depends on cttok_pkg for the token kind type.
interface cttok_token_if;
    import cttok_pkg::*;

    logic        valid;
    logic        ready;
    token_kind_t token_kind;
    logic [31:0] value;
    logic [63:0] id_text;
    logic [3:0]  text_length;
    logic        last;

    modport source (output valid, output token_kind, output value, output id_text,
                    output text_length, output last, input ready);
    modport sink   (input valid, input token_kind, input value, input id_text,
                    input text_length, input last, output ready);
endinterface

FILE: hdl/command_text_tokenizer_top.sv
// Command text tokenizer: turns a character stream into tokens.
// Depends on cttok_pkg, cttok_char_if and cttok_token_if.
//
// Usage:
//   chars  : sink, one character per beat; a zero character ends the text.
//   tokens : source, one token per beat (kind, value, kept text, length,
//            and last marking the final token caused by a character).
//   A character is captured into an input register, classified by a single
//   level of logic against the scanner state, and its token lands in an
//   output register.
//   Throughput: one character per cycle while no token waits on a held
//   tokens channel. A character that closes a token and is a token itself
//   (also end of text right after a hex prefix) occupies the scan stage
//   once per token, and the next character waits meanwhile.
//   Stall: when tokens is held, the output register holds its beat and a
//   token-producing character waits in the input register; characters that
//   produce no token keep flowing while the output register is full.
//   Reset: scanner returns to idle with empty token text; both registers
//   are emptied.
module command_text_tokenizer_top #(
    parameter int MAX_TOKEN_CHARS = cttok_pkg::MAX_TOKEN_CHARS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cttok_char_if.sink    chars,
    cttok_token_if.source tokens
);
    import cttok_pkg::*;

    localparam logic [3:0] MAX_CNT = 4'(MAX_TOKEN_CHARS);

    // Input register
    logic       in_valid_reg;
    logic [7:0] ch_reg;

    // Scanner state
    mode_t       mode_reg, mode_next;
    logic [31:0] acc_reg, acc_next;
    logic [63:0] text_reg, text_next;
    logic [3:0]  cnt_reg, cnt_next;

    // Output register
    logic        out_valid_reg;
    token_kind_t kind_reg;
    logic [31:0] value_reg;
    logic [63:0] text_out_reg;
    logic [3:0]  len_reg;
    logic        last_reg;

    // Idle handling of the current character
    logic        idle_emit;
    token_kind_t idle_kind;
    mode_t       idle_mode;
    logic [31:0] idle_acc;
    logic [63:0] idle_text;
    logic [3:0]  idle_cnt;

    // Token state as seen by the scan (a pending leading zero already kept)
    logic [31:0] b_acc;
    logic [63:0] b_text;
    logic [3:0]  b_cnt;
    logic        k_ok;
    logic [63:0] k_text;
    logic [31:0] k_acc10, k_acc16, dv;

    // Scan stage results
    logic        st_emit;
    logic        st_consume;
    token_kind_t st_kind;
    logic [31:0] st_value;
    logic [63:0] st_text;
    logic [3:0]  st_len;
    logic        st_last;
    logic        do_finish;
    logic        fin_data;
    token_kind_t fin_kind;

    logic fire;
    logic in_ready;
    logic out_space;

    // Classify the character from a cleared token state
    always_comb
    begin
        idle_emit = 1'b0;
        idle_kind = KIND_ERROR;
        idle_mode = MODE_IDLE;
        idle_acc  = 32'd0;
        idle_text = 64'd0;
        idle_cnt  = 4'd0;
        case (ch_reg) inside
            CH_NUL:                      begin idle_emit = 1'b1; idle_kind = KIND_EOT; end
            CH_SP, CH_LF, CH_TAB, CH_CR: ;
            CH_LT:    begin idle_emit = 1'b1; idle_kind = KIND_CMD_START; end
            CH_GT:    begin idle_emit = 1'b1; idle_kind = KIND_CMD_END; end
            CH_DOT:   begin idle_emit = 1'b1; idle_kind = KIND_DOT; end
            CH_COLON: begin idle_emit = 1'b1; idle_kind = KIND_COLON; end
            CH_ZERO:  idle_mode = MODE_ZERO;
            default:
            begin
                if (is_digit(ch_reg))
                begin
                    idle_mode = MODE_DEC;
                    idle_acc  = {28'd0, digit_value(ch_reg)};
                    idle_text = {56'd0, ch_reg};
                    idle_cnt  = 4'd1;
                end
                else if (is_name_start(ch_reg))
                begin
                    idle_mode = MODE_IDENT;
                    idle_text = {56'd0, ch_reg};
                    idle_cnt  = 4'd1;
                end
                else
                begin
                    idle_emit = 1'b1;
                    idle_kind = KIND_ERROR;
                end
            end
        endcase
    end

    // Keep one more character onto the token
    always_comb
    begin
        if (mode_reg == MODE_ZERO)
        begin
            b_acc  = 32'd0;
            b_text = {56'd0, CH_ZERO};
            b_cnt  = 4'd1;
        end
        else
        begin
            b_acc  = acc_reg;
            b_text = text_reg;
            b_cnt  = cnt_reg;
        end
        k_ok   = (b_cnt < MAX_CNT);
        dv     = {28'd0, digit_value(ch_reg)};
        k_text = b_text;
        for (int i = 0; i < TEXT_BYTES; i++)
        begin
            if (b_cnt == 4'(i))
            begin
                k_text[8*i +: 8] = ch_reg;
            end
        end
        k_acc10 = (b_acc << 3) + (b_acc << 1) + dv;
        k_acc16 = (b_acc << 4) | dv;
    end

    // Scan stage: at most one token per cycle while the output has space, next scanner state
    always_comb
    begin
        st_emit    = 1'b0;
        st_consume = 1'b1;
        st_kind    = KIND_ERROR;
        st_value   = 32'd0;
        st_text    = 64'd0;
        st_len     = 4'd0;
        st_last    = 1'b1;
        do_finish  = 1'b0;
        fin_data   = 1'b1;
        fin_kind   = KIND_NUMBER;
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        text_next  = text_reg;
        cnt_next   = cnt_reg;
        unique case (mode_reg)
            MODE_ZERO:
            begin
                if ((ch_reg == CH_LOWX) || (ch_reg == CH_UPX))
                begin
                    mode_next = MODE_PREFIX;
                end
                else if (is_digit(ch_reg))
                begin
                    mode_next = MODE_DEC;
                    acc_next  = k_ok ? k_acc10 : b_acc;
                    text_next = k_ok ? k_text : b_text;
                    cnt_next  = k_ok ? 4'(b_cnt + 4'd1) : b_cnt;
                end
                else
                begin
                    do_finish = 1'b1;
                    fin_kind  = KIND_NUMBER;
                end
            end
            MODE_PREFIX:
            begin
                if (ch_reg == CH_NUL)
                begin
                    do_finish = 1'b1;
                    fin_kind  = KIND_ERROR;
                    fin_data  = 1'b0;
                end
                else if (is_digit(ch_reg) || is_hex_letter(ch_reg))
                begin
                    mode_next = MODE_HEX;
                    acc_next  = k_ok ? k_acc16 : b_acc;
                    text_next = k_ok ? k_text : b_text;
                    cnt_next  = k_ok ? 4'(b_cnt + 4'd1) : b_cnt;
                end
                else if (is_name_start(ch_reg))
                begin
                    mode_next = MODE_IDENT;
                    text_next = k_ok ? k_text : b_text;
                    cnt_next  = k_ok ? 4'(b_cnt + 4'd1) : b_cnt;
                end
                else
                begin
                    // bad character after the prefix is swallowed by the error
                    st_emit   = 1'b1;
                    st_kind   = KIND_ERROR;
                    mode_next = MODE_IDLE;
                    acc_next  = 32'd0;
                    text_next = 64'd0;
                    cnt_next  = 4'd0;
                end
            end
            MODE_DEC:
            begin
                if (is_digit(ch_reg))
                begin
                    acc_next  = k_ok ? k_acc10 : b_acc;
                    text_next = k_ok ? k_text : b_text;
                    cnt_next  = k_ok ? 4'(b_cnt + 4'd1) : b_cnt;
                end
                else
                begin
                    do_finish = 1'b1;
                    fin_kind  = KIND_NUMBER;
                end
            end
            MODE_HEX:
            begin
                if (is_digit(ch_reg) || is_hex_letter(ch_reg))
                begin
                    acc_next  = k_ok ? k_acc16 : b_acc;
                    text_next = k_ok ? k_text : b_text;
                    cnt_next  = k_ok ? 4'(b_cnt + 4'd1) : b_cnt;
                end
                else
                begin
                    do_finish = 1'b1;
                    fin_kind  = KIND_HEX;
                end
            end
            MODE_IDENT:
            begin
                if (is_name_start(ch_reg) || is_digit(ch_reg))
                begin
                    text_next = k_ok ? k_text : b_text;
                    cnt_next  = k_ok ? 4'(b_cnt + 4'd1) : b_cnt;
                end
                else
                begin
                    do_finish = 1'b1;
                    fin_kind  = KIND_IDENT;
                end
            end
            default:
            begin
                st_emit   = idle_emit;
                st_kind   = idle_kind;
                mode_next = idle_mode;
                acc_next  = idle_acc;
                text_next = idle_text;
                cnt_next  = idle_cnt;
            end
        endcase

        // Close the open token; the closing character is scanned from idle, held in
        // the input register for a further scan if it gives a token of its own
        if (do_finish)
        begin
            st_emit = 1'b1;
            st_kind = fin_kind;
            if (fin_data)
            begin
                st_value = (fin_kind == KIND_IDENT) ? 32'd0 : b_acc;
                st_text  = b_text;
                st_len   = b_cnt;
            end
            if (idle_emit)
            begin
                st_consume = 1'b0;
                st_last    = 1'b0;
                mode_next  = MODE_IDLE;
                acc_next   = 32'd0;
                text_next  = 64'd0;
                cnt_next   = 4'd0;
            end
            else
            begin
                mode_next = idle_mode;
                acc_next  = idle_acc;
                text_next = idle_text;
                cnt_next  = idle_cnt;
            end
        end
    end

    // Handshake
    assign out_space    = !out_valid_reg || tokens.ready;
    assign fire         = in_valid_reg && (!st_emit || out_space);
    assign in_ready     = !in_valid_reg || (fire && st_consume);
    assign chars.ready  = in_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire && st_consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && in_ready)
        begin
            ch_reg <= chars.ch;
        end
    end

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= 32'd0;
            text_reg <= 64'd0;
            cnt_reg  <= 4'd0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            text_reg <= text_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && st_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tokens.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && st_emit)
        begin
            kind_reg     <= st_kind;
            value_reg    <= st_value;
            text_out_reg <= st_text;
            len_reg      <= st_len;
            last_reg     <= st_last;
        end
    end

    assign tokens.valid       = out_valid_reg;
    assign tokens.token_kind  = kind_reg;
    assign tokens.value       = value_reg;
    assign tokens.id_text     = text_out_reg;
    assign tokens.text_length = len_reg;
    assign tokens.last        = last_reg;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("kept count beyond token limit");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> (cnt_reg == 4'd0 && acc_reg == 32'd0
                                     && text_reg == 64'd0))
        else $error("idle scanner holds token state");

    a_zero_prefix_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ZERO || mode_reg == MODE_PREFIX) |-> (cnt_reg == 4'd0))
        else $error("text kept before leading zero is resolved");

    a_split_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !st_consume) |=> (in_valid_reg && mode_reg == MODE_IDLE
                                   && $stable(ch_reg)))
        else $error("closing character lost after first token");

    a_split_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && st_emit && !st_consume) |=> (out_valid_reg && !last_reg))
        else $error("first of two tokens marked last");

    a_plain_no_text: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_NUMBER && kind_reg != KIND_HEX
         && kind_reg != KIND_IDENT) |-> (len_reg == 4'd0 && text_out_reg == 64'd0
                                         && value_reg == 32'd0))
        else $error("token without text carries data");

endmodule
